/* rtl/pei_pkg.sv */
//------------------------------------------------------------------------------
// pei_pkg
// shared constants, opcodes and the multiplier request type for the integrator
//------------------------------------------------------------------------------
`default_nettype none
package pei_pkg;
	localparam int FRAC_BITS = 16;
	localparam int TAYLOR_TERMS = 12;
	localparam logic [31:0] LN2_Q30 = 32'd744261118;

	localparam logic [2:0] OP_FORCE = 3'd0;
	localparam logic [2:0] OP_INTEG = 3'd1;
	localparam logic [2:0] OP_LDPOS = 3'd2;
	localparam logic [2:0] OP_LDVEL = 3'd3;
	localparam logic [2:0] OP_REMOVE = 3'd4;

	localparam logic [2:0] REG_IMASS = 3'd0;
	localparam logic [2:0] REG_DAMP = 3'd1;
	localparam logic [2:0] REG_LIFE = 3'd2;
	localparam logic [2:0] REG_SSL = 3'd3;
	localparam logic [2:0] REG_SKNOWN = 3'd4;
	localparam logic [2:0] REG_AX = 3'd5;
	localparam logic [2:0] REG_AY = 3'd6;
	localparam logic [2:0] REG_AZ = 3'd7;

	typedef struct packed {
		logic signed [33:0] a;
		logic signed [33:0] b;
	} mul_req_t;

	// reciprocals for the taylor divide by k, 2^32/k rounded up (floor of
	// term*recip >> 32 equals term/k for the term range used: term < 2^30)
	function automatic logic [35:0] recip_k(input logic [3:0] k);
		case (k)
			4'd1: recip_k = 36'd4294967296;
			4'd2: recip_k = 36'd2147483648;
			4'd3: recip_k = 36'd1431655766;
			4'd4: recip_k = 36'd1073741824;
			4'd5: recip_k = 36'd858993460;
			4'd6: recip_k = 36'd715827883;
			4'd7: recip_k = 36'd613566757;
			4'd8: recip_k = 36'd536870912;
			4'd9: recip_k = 36'd477218589;
			4'd10: recip_k = 36'd429496730;
			4'd11: recip_k = 36'd390451573;
			4'd12: recip_k = 36'd357913942;
			default: recip_k = 36'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

/* rtl/pei_mul.sv */
//------------------------------------------------------------------------------
// pei_mul
// shared registered signed 34x34 multiplier, product in the cycle after the request
//------------------------------------------------------------------------------
`default_nettype none
module pei_mul
	import pei_pkg::*;
(
	input  wire logic        clk,
	input  wire mul_req_t    req,
	output logic signed [67:0] prod
);
	always_ff @(posedge clk) begin
		prod <= req.a * req.b;
	end
endmodule
`default_nettype wire

/* rtl/particle_euler_integrator_top.sv */
//------------------------------------------------------------------------------
// particle_euler_integrator_top
// damped euler integration of one particle in q16.16, one shared multiplier
//------------------------------------------------------------------------------
// channel   dir  handshake         contents
// s_axis    in   tvalid/tready     tdata: opcode, vec_x, vec_y, vec_z, delta_time
// m_axis    out  tvalid/tready     tdata: pos_x..vel_z, shrink_scale; tuser: expired, shrink_valid
// cfg       in   wr_en             wr_index selects register, wr_data value
//
// one request is taken at a time. a non-integrate request, or an integrate of a
// removed or zero-imass particle, goes straight to the result. an integrate uses
// the shared 34x34 multiplier (each product: issue, then use) for the 9 vector
// products, 16 log2 squarings, dt scaling, 13 taylor multiplies plus 12 divides
// and 3 damping products. reset clears configuration, particle and control state
// (damping to 0x10000); a result held on m_axis blocks the next request until taken.
//------------------------------------------------------------------------------
`default_nettype none
module particle_euler_integrator_top
	import pei_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// opcode[2:0], vec_x[34:3], vec_y[66:35], vec_z[98:67], delta_time[118:99], zero pad
	input  wire logic [119:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, shrink_scale, 32 bits each
	output logic [223:0]      m_axis_tdata,
	// expired[0], shrink_valid[1]
	output logic [1:0]        m_axis_tuser,
	input  wire logic         wr_en,
	input  wire logic [2:0]   wr_index,
	input  wire logic [31:0]  wr_data
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_VEC = 4'd1;   // force*imass, pos, vel per axis
	localparam logic [3:0] ST_LOGSQ = 4'd2;
	localparam logic [3:0] ST_EDT = 4'd3;
	localparam logic [3:0] ST_X = 4'd4;
	localparam logic [3:0] ST_TMUL = 4'd5;
	localparam logic [3:0] ST_TDIV = 4'd6;
	localparam logic [3:0] ST_FAC = 4'd7;
	localparam logic [3:0] ST_DAMP = 4'd8;
	localparam logic [3:0] ST_AGE = 4'd9;
	localparam logic [3:0] ST_OUT = 4'd10;

	logic [31:0] imass_q, damp_q, ssl_q;
	logic signed [31:0] life_q;
	logic sknown_q;
	logic signed [31:0] acc_q [3];
	logic signed [31:0] pos_q [3], vel_q [3], frc_q [3];
	logic [31:0] age_q;
	logic removed_q;

	logic [3:0] state_q;
	logic ph_q;               // 0 issue product, 1 consume product
	logic [1:0] ax_q;
	logic [1:0] sub_q;        // step within an axis
	logic [4:0] cnt_q;
	logic [19:0] dt_q;
	logic signed [31:0] a_q;
	logic [31:0] m_q;         // q30 mantissa (< 2^31)
	logic [15:0] lfrac_q;
	logic signed [5:0] lint_q;
	logic signed [31:0] lg_c; // log2 value, q16
	logic signed [47:0] e_q;
	logic [31:0] x_q, term_q;
	logic [35:0] sum_q;
	logic [31:0] fac_q;
	logic expd_q, svalid_q;
	logic signed [31:0] shrink_q;

	mul_req_t req;
	logic signed [67:0] prod;
	pei_mul u_mul (.clk(clk), .req(req), .prod(prod));

	function automatic logic signed [31:0] sat(input logic signed [67:0] x);
		if (x > 68'sh7FFFFFFF) sat = 32'sh7FFFFFFF;
		else if (x < -68'sh80000000) sat = 32'sh80000000;
		else sat = x[31:0];
	endfunction

	logic signed [67:0] pshr;
	assign pshr = prod >>> FRAC_BITS;

	assign lg_c = {{10{lint_q[5]}}, lint_q, lfrac_q};

	// leading one position of damping (zero taken as one)
	logic [31:0] dz;
	logic [4:0] lp;
	always_comb begin
		dz = (damp_q == 32'd0) ? 32'd1 : damp_q;
		lp = 5'd0;
		for (int i = 0; i < 32; i++) if (dz[i]) lp = 5'(i);
	end

	// exp2 scaling
	logic signed [47:0] n_e;
	logic signed [48:0] shf;
	logic [67:0] sh_l;
	logic [31:0] fac_c;
	always_comb begin
		n_e = e_q >>> FRAC_BITS;
		shf = 49'(n_e) + 49'(FRAC_BITS - 30);
		sh_l = '0;
		fac_c = '0;
		if (shf > 49'sd1) fac_c = 32'hFFFFFFFF;
		else if (shf >= 0) begin
			sh_l = 68'(sum_q) << shf[0];
			fac_c = (sh_l > 68'hFFFFFFFF) ? 32'hFFFFFFFF : sh_l[31:0];
		end else if (-shf >= 49'sd63) fac_c = '0;
		else fac_c = 32'(sum_q >> (-shf));
	end

	always_comb begin
		req.a = '0;
		req.b = '0;
		case (state_q)
			ST_VEC: begin
				case (sub_q)
					2'd0: begin req.a = 34'(frc_q[ax_q]); req.b = {2'b0, imass_q}; end
					2'd1: begin req.a = 34'(vel_q[ax_q]); req.b = {14'b0, dt_q}; end
					default: begin req.a = 34'(a_q); req.b = {14'b0, dt_q}; end
				endcase
			end
			ST_LOGSQ: begin req.a = {2'b0, m_q}; req.b = {2'b0, m_q}; end
			ST_EDT: begin req.a = 34'(lg_c); req.b = {14'b0, dt_q}; end
			ST_X: begin
				// fraction of e moved to q30
				req.a = {4'b0, e_q[15:0], 14'b0};
				req.b = {2'b0, LN2_Q30};
			end
			ST_TMUL: begin req.a = {2'b0, term_q}; req.b = {2'b0, x_q}; end
			ST_TDIV: begin req.a = {2'b0, term_q}; req.b = 34'(recip_k(cnt_q[3:0])); end
			ST_DAMP: begin req.a = 34'(vel_q[ax_q]); req.b = {2'b0, fac_q}; end
			default: ;
		endcase
	end

	logic s_acc, m_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_acc = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = {shrink_q, vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
	assign m_axis_tuser = {svalid_q, expd_q};

	logic signed [33:0] age_rem;
	logic [32:0] age_sum;
	logic [31:0] age_n;
	assign age_sum = {1'b0, age_q} + {13'b0, dt_q};
	assign age_n = age_sum[32] ? 32'hFFFFFFFF : age_sum[31:0];
	assign age_rem = 34'(life_q) - $signed({2'b0, age_n});

	logic [63:0] msq;
	assign msq = 64'(prod) >> 30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imass_q <= '0; damp_q <= 32'h10000; life_q <= '0; ssl_q <= '0;
			sknown_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0; pos_q[i] <= '0; vel_q[i] <= '0; frc_q[i] <= '0;
			end
			age_q <= '0; removed_q <= 1'b0; state_q <= ST_IDLE;
			ph_q <= 1'b0; ax_q <= '0; sub_q <= '0; cnt_q <= '0;
			expd_q <= 1'b0; svalid_q <= 1'b0; shrink_q <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_IMASS: imass_q <= wr_data;
					REG_DAMP: damp_q <= wr_data;
					REG_LIFE: life_q <= wr_data;
					REG_SSL: ssl_q <= wr_data;
					REG_SKNOWN: sknown_q <= wr_data[0];
					REG_AX: acc_q[0] <= wr_data;
					REG_AY: acc_q[1] <= wr_data;
					REG_AZ: acc_q[2] <= wr_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (s_acc) begin
					dt_q <= s_axis_tdata[118:99];
					expd_q <= removed_q || (s_axis_tdata[2:0] == OP_REMOVE);
					svalid_q <= 1'b0;
					shrink_q <= '0;
					if (s_axis_tdata[2:0] == OP_INTEG && !removed_q && imass_q != 32'd0) begin
						state_q <= ST_VEC; ax_q <= '0; sub_q <= '0; ph_q <= 1'b0;
					end else state_q <= ST_OUT;
					case (s_axis_tdata[2:0])
						OP_FORCE: for (int i = 0; i < 3; i++)
							frc_q[i] <= sat(68'(frc_q[i]) + 68'($signed(s_axis_tdata[35+32*i-32 +: 32])));
						OP_LDPOS: for (int i = 0; i < 3; i++)
							pos_q[i] <= s_axis_tdata[3+32*i +: 32];
						OP_LDVEL: for (int i = 0; i < 3; i++)
							vel_q[i] <= s_axis_tdata[3+32*i +: 32];
						OP_REMOVE: removed_q <= 1'b1;
						default: ;
					endcase
				end
				ST_VEC: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						case (sub_q)
							2'd0: begin
								a_q <= sat(68'(acc_q[ax_q]) + pshr);
								sub_q <= 2'd1;
							end
							2'd1: begin
								pos_q[ax_q] <= sat(68'(pos_q[ax_q]) + pshr);
								sub_q <= 2'd2;
							end
							default: begin
								sub_q <= 2'd0;
								if (ax_q == 2'd1 && sat(68'(vel_q[1]) + pshr) > 32'sh10000)
									vel_q[1] <= 32'sh10000;
								else vel_q[ax_q] <= sat(68'(vel_q[ax_q]) + pshr);
								if (ax_q == 2'd2) begin
									ax_q <= '0;
									state_q <= ST_LOGSQ;
									cnt_q <= 5'd1;
									lfrac_q <= '0;
									lint_q <= 6'(lp) - 6'(FRAC_BITS);
									m_q <= (lp <= 5'd30) ? (dz << (5'd30 - lp)) : (dz >> 1);
								end else ax_q <= ax_q + 2'd1;
							end
						endcase
					end
				end
				ST_LOGSQ: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (msq >= 64'h80000000) begin
							m_q <= 32'(msq >> 1);
							lfrac_q[4'(5'(FRAC_BITS) - cnt_q)] <= 1'b1;
						end else m_q <= msq[31:0];
						if (cnt_q == 5'(FRAC_BITS)) state_q <= ST_EDT;
						else cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_EDT: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						e_q <= -48'(pshr);
						state_q <= ST_X;
					end
				end
				ST_X: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						x_q <= 32'(prod >>> 30);
						term_q <= 32'h40000000;
						sum_q <= 36'h40000000;
						cnt_q <= 5'd1;
						state_q <= ST_TMUL;
					end
				end
				ST_TMUL: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						term_q <= 32'(prod >>> 30);
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						term_q <= 32'(prod >>> 32);
						sum_q <= sum_q + 36'(prod >>> 32);
						if (cnt_q == 5'(TAYLOR_TERMS)) state_q <= ST_FAC;
						else begin cnt_q <= cnt_q + 5'd1; state_q <= ST_TMUL; end
					end
				end
				ST_FAC: begin
					fac_q <= fac_c;
					ax_q <= '0;
					state_q <= ST_DAMP;
				end
				ST_DAMP: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						vel_q[ax_q] <= sat(pshr);
						if (ax_q == 2'd2) state_q <= ST_AGE;
						else ax_q <= ax_q + 2'd1;
					end
				end
				ST_AGE: begin
					state_q <= ST_OUT;
					if (life_q > 0) begin
						age_q <= age_n;
						shrink_q <= sat(68'(age_rem));
						svalid_q <= sknown_q && (age_rem < $signed({2'b0, ssl_q}));
						if ($signed({2'b0, age_n}) > 34'(life_q)) expd_q <= 1'b1;
						else for (int i = 0; i < 3; i++) frc_q[i] <= '0;
					end else for (int i = 0; i < 3; i++) frc_q[i] <= '0;
				end
				ST_OUT: if (m_acc) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready while result held");
	a_yclamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOGSQ) |-> (vel_q[1] <= 32'sh10000)) else $error("vel_y clamp");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> m_axis_tvalid || !s_axis_tready) else $error("no progress");
endmodule
`default_nettype wire

/* sim/tb_particle_euler_integrator_top.sv */
//------------------------------------------------------------------------------
// tb_particle_euler_integrator_top
// drives opcode requests into the integrator under random idling on both
// sides, predicts every result with a bit-exact fixed-point model of the
// damped euler step and compares each result field by field
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_particle_euler_integrator_top
	import pei_pkg::*;
;

	localparam int N_RANDOM = 1150;

	typedef struct packed {
		logic [19:0] dt;
		logic [31:0] vz;
		logic [31:0] vy;
		logic [31:0] vx;
		logic [2:0]  op;
	} step_req_t;

	typedef struct {
		logic        expired;
		logic [31:0] pos [3];
		logic [31:0] vel [3];
		logic [31:0] shrink;
		logic        shrink_ok;
	} particle_out_t;

	// directed table: a step request plus an optional typed-in answer
	typedef struct {
		logic [2:0]  op;
		logic [31:0] vx, vy, vz;
		logic [19:0] dt;
		bit          typed;
		logic        t_expired;
		logic [31:0] t_px;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [223:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         wr_en;
	logic [2:0]   wr_index;
	logic [31:0]  wr_data;

	// predictor copy of configuration and particle state
	logic [31:0]        p_imass, p_damp, p_ssl;
	logic               p_sknown;
	logic signed [31:0] p_life;
	logic signed [31:0] p_accel [3];
	logic signed [31:0] p_pos [3], p_vel [3], p_force [3];
	logic [31:0]        p_age;
	logic               p_removed;

	particle_out_t expected_q [$];
	int  fail_count;
	int  results_seen;
	int  hold_off;      // receiver hold-off requested by the stimulus, in cycles
	bit  stall_always;

	particle_euler_integrator_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// generous fixed time limit covering every integrate plus long stalls
	initial begin
		#30_000_000;
		$display("tb_particle_euler_integrator_top failed");
		$finish;
	end

	// ---------------- fixed-point helpers ----------------
	function automatic longint sat_s32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// floor shift of a product that may exceed 64 bits
	function automatic longint floor_prod(input longint a, input longint b);
		logic signed [127:0] p;
		p = 128'(signed'(a)) * 128'(signed'(b));
		return longint'(p >>> FRAC_BITS);
	endfunction

	function automatic longint damp_log2(input logic [31:0] d);
		int p;
		logic [63:0] m;
		longint frac;
		if (d == 0) d = 32'd1;
		p = 31;
		while (p > 0 && !d[p]) p--;
		if (p <= 30) m = 64'(d) << (30 - p);
		else m = 64'(d) >> 1;
		frac = 0;
		for (int i = 1; i <= FRAC_BITS; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | (64'sd1 << (FRAC_BITS - i));
			end
		end
		return longint'(p - FRAC_BITS) * (64'sd1 << FRAC_BITS) + frac;
	endfunction

	function automatic logic [31:0] damp_exp2(input longint e);
		longint n, shift;
		logic [63:0] f, x, term, sum, r;
		n = e >>> FRAC_BITS;
		f = 64'(e) & ((64'd1 << FRAC_BITS) - 1);
		x = ((f << (30 - FRAC_BITS)) * 64'(LN2_Q30)) >> 30;
		term = 64'd1 << 30;
		sum = term;
		for (int k = 1; k <= TAYLOR_TERMS; k++) begin
			term = ((term * x) >> 30) / k;
			sum += term;
		end
		shift = n + FRAC_BITS - 30;
		if (shift > 1) return 32'hFFFF_FFFF;
		if (shift >= 0) begin
			r = sum << shift;
			return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
		end
		if (-shift >= 63) return 32'd0;
		r = sum >> (-shift);
		return r[31:0];
	endfunction

	// integrate step; returns expired
	function automatic logic euler_advance(input logic [19:0] dt, output logic [31:0] shrink,
			output logic shrink_ok);
		longint a, e, fac, rem, ag;
		shrink = 0;
		shrink_ok = 0;
		if (p_removed) return 1'b1;
		if (p_imass == 0) return 1'b0;
		for (int i = 0; i < 3; i++) begin
			a = sat_s32(longint'(p_accel[i]) + floor_prod(p_force[i], longint'(p_imass)));
			p_pos[i] = 32'(sat_s32(longint'(p_pos[i]) + floor_prod(p_vel[i], longint'(dt))));
			p_vel[i] = 32'(sat_s32(longint'(p_vel[i]) + floor_prod(a, longint'(dt))));
		end
		if (p_vel[1] > 32'sh0001_0000) p_vel[1] = 32'sh0001_0000;
		e = -floor_prod(damp_log2(p_damp), longint'(dt));
		fac = longint'(damp_exp2(e));
		for (int i = 0; i < 3; i++)
			p_vel[i] = 32'(sat_s32(floor_prod(p_vel[i], fac)));
		if (p_life > 0) begin
			ag = longint'(p_age) + longint'(dt);
			p_age = (ag > 64'sh FFFF_FFFF) ? 32'hFFFF_FFFF : ag[31:0];
			rem = longint'(p_life) - longint'(p_age);
			shrink = 32'(sat_s32(rem));
			shrink_ok = p_sknown && (rem < longint'(p_ssl));
			if (longint'(p_age) > longint'(p_life)) return 1'b1;
		end
		for (int i = 0; i < 3; i++) p_force[i] = 0;
		return 1'b0;
	endfunction

	function automatic particle_out_t particle_predict(input step_req_t r);
		particle_out_t o;
		logic signed [31:0] v [3];
		v[0] = r.vx;
		v[1] = r.vy;
		v[2] = r.vz;
		o.expired = p_removed;
		o.shrink = 0;
		o.shrink_ok = 0;
		case (r.op)
			OP_FORCE:
				for (int i = 0; i < 3; i++)
					p_force[i] = 32'(sat_s32(longint'(p_force[i]) + longint'(v[i])));
			OP_INTEG: o.expired = euler_advance(r.dt, o.shrink, o.shrink_ok);
			OP_LDPOS: for (int i = 0; i < 3; i++) p_pos[i] = v[i];
			OP_LDVEL: for (int i = 0; i < 3; i++) p_vel[i] = v[i];
			OP_REMOVE: begin
				p_removed = 1'b1;
				o.expired = 1'b1;
			end
			default: ;
		endcase
		for (int i = 0; i < 3; i++) begin
			o.pos[i] = p_pos[i];
			o.vel[i] = p_vel[i];
		end
		return o;
	endfunction

	function automatic void predictor_reset();
		p_imass = 0;
		p_damp = 32'h0001_0000;
		p_life = 0;
		p_ssl = 0;
		p_sknown = 0;
		for (int i = 0; i < 3; i++) begin
			p_accel[i] = 0;
			p_pos[i] = 0;
			p_vel[i] = 0;
			p_force[i] = 0;
		end
		p_age = 0;
		p_removed = 0;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got,
			want);
		fail_count++;
	endtask

	// ---------------- result side ----------------
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				particle_out_t want;
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", 32'd1, 32'd0);
				end else begin
					want = expected_q.pop_front();
					if (m_axis_tuser[0] !== want.expired)
						report_mismatch("expired", 32'(m_axis_tuser[0]), 32'(want.expired));
					if (m_axis_tuser[1] !== want.shrink_ok)
						report_mismatch("shrink_valid", 32'(m_axis_tuser[1]),
							32'(want.shrink_ok));
					for (int i = 0; i < 3; i++) begin
						if (m_axis_tdata[32*i +: 32] !== want.pos[i])
							report_mismatch($sformatf("pos[%0d]", i), m_axis_tdata[32*i +: 32],
								want.pos[i]);
						if (m_axis_tdata[96 + 32*i +: 32] !== want.vel[i])
							report_mismatch($sformatf("vel[%0d]", i),
								m_axis_tdata[96 + 32*i +: 32], want.vel[i]);
					end
					if (m_axis_tdata[223:192] !== want.shrink)
						report_mismatch("shrink_scale", m_axis_tdata[223:192], want.shrink);
				end
				results_seen++;
			end
			// long hold-off counted here so the block fills and stalls its input
			if (hold_off > 0) begin
				m_axis_tready <= 1'b0;
				hold_off--;
			end else if (stall_always) begin
				m_axis_tready <= 1'b1;
			end else begin
				gap = $urandom_range(0, 99);
				m_axis_tready <= (gap < 70) || (gap < 75 && $urandom_range(0, 1));
			end
		end
	end

	// ---------------- request side ----------------
	task automatic send_step(input step_req_t r, input bit typed, input logic t_exp,
			input logic [31:0] t_px);
		particle_out_t o;
		int gap;
		if (!stall_always && $urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {1'b0, r};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		s_axis_tvalid <= 1'b0;
		o = particle_predict(r);
		// typed-in answers double-check the predictor where the value is obvious
		if (typed && o.expired !== t_exp)
			report_mismatch("directed expired", 32'(o.expired), 32'(t_exp));
		if (typed && o.pos[0] !== t_px)
			report_mismatch("directed pos_x", o.pos[0], t_px);
		expected_q.push_back(o);
		// the block is busy for at least this cycle after taking a request
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_IMASS: p_imass = val;
			REG_DAMP: p_damp = val;
			REG_LIFE: p_life = val;
			REG_SSL: p_ssl = val;
			REG_SKNOWN: p_sknown = val[0];
			REG_AX: p_accel[0] = val;
			REG_AY: p_accel[1] = val;
			REG_AZ: p_accel[2] = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// config only while idle: drain, then let the block settle
	task automatic wait_idle();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_vec();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [19:0] rand_dt();
		case ($urandom_range(0, 7))
			0: return 20'hFFFFF;
			1: return 20'd0;
			default: return 20'($urandom_range(0, 20'h1_0000));
		endcase
	endfunction

	task automatic random_config(input int style);
		write_reg(REG_IMASS, (style == 0) ? 32'd0 :
			($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(1, 32'h0004_0000));
		write_reg(REG_DAMP, (style == 1) ? 32'hFFFF_FFFF : (style == 2) ? 32'd0 :
			($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(32'h0001_0000,
			32'h0002_0000));
		write_reg(REG_LIFE, ($urandom_range(0, 2) == 0) ? $urandom() :
			$urandom_range(1, 32'h0010_0000));
		write_reg(REG_SSL, (style == 3) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0008_0000));
		write_reg(REG_SKNOWN, 32'($urandom_range(0, 1)));
		write_reg(REG_AX, (style == 1) ? 32'h8000_0000 : rand_vec());
		write_reg(REG_AY, (style == 1) ? 32'h7FFF_FFFF : rand_vec());
		write_reg(REG_AZ, rand_vec());
	endtask

	dir_row_t dir_rows [$];

	initial begin
		step_req_t r;
		int phase_left;
		fail_count = 0;
		results_seen = 0;
		hold_off = 0;
		stall_always = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		predictor_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: immovable particle, loads, forces and undefined opcodes
		dir_rows = '{
			'{OP_INTEG, 32'd0, 32'd0, 32'd0, 20'h10000, 1, 1'b0, 32'd0},
			'{OP_LDPOS, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 20'd0, 1, 1'b0, 32'h7FFF_FFFF},
			'{OP_LDVEL, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 20'd0, 1, 1'b0,
				32'h7FFF_FFFF},
			'{OP_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 20'd0, 0, 1'b0, 32'd0},
			'{OP_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 20'd0, 0, 1'b0, 32'd0},
			'{OP_INTEG, 32'd0, 32'd0, 32'd0, 20'hFFFFF, 1, 1'b0, 32'h7FFF_FFFF},
			'{3'd5, 32'd0, 32'd0, 32'd0, 20'd0, 1, 1'b0, 32'h7FFF_FFFF},
			'{3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1, 1'b0,
				32'h7FFF_FFFF}
		};
		foreach (dir_rows[i]) begin
			r = '{dir_rows[i].dt, dir_rows[i].vz, dir_rows[i].vy, dir_rows[i].vx, dir_rows[i].op};
			send_step(r, dir_rows[i].typed, dir_rows[i].t_expired, dir_rows[i].t_px);
		end
		wait_idle();

		// movable particle with extreme damping and saturating motion, then removal
		write_reg(REG_IMASS, 32'hFFFF_FFFF);
		write_reg(REG_DAMP, 32'd0);
		write_reg(REG_LIFE, 32'h0002_0000);
		write_reg(REG_SSL, 32'hFFFF_FFFF);
		write_reg(REG_SKNOWN, 32'd1);
		write_reg(REG_AX, 32'h7FFF_FFFF);
		write_reg(REG_AY, 32'h8000_0000);
		write_reg(REG_AZ, 32'h0001_0000);
		dir_rows = '{
			'{OP_LDVEL, 32'h0001_0000, 32'h0005_0000, 32'h8000_0000, 20'd0, 0, 1'b0, 32'd0},
			'{OP_INTEG, 32'd0, 32'd0, 32'd0, 20'h0_8000, 0, 1'b0, 32'd0},
			'{OP_FORCE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 20'd0, 0, 1'b0, 32'd0},
			'{OP_INTEG, 32'd0, 32'd0, 32'd0, 20'h1_0000, 0, 1'b0, 32'd0},
			'{OP_INTEG, 32'd0, 32'd0, 32'd0, 20'hFFFFF, 0, 1'b0, 32'd0},
			'{OP_FORCE, 32'd3, 32'd3, 32'd3, 20'd0, 0, 1'b0, 32'd0},
			'{OP_INTEG, 32'd0, 32'd0, 32'd0, 20'd1, 0, 1'b0, 32'd0},
			'{OP_REMOVE, 32'd0, 32'd0, 32'd0, 20'd0, 0, 1'b0, 32'd0},
			'{OP_INTEG, 32'd0, 32'd0, 32'd0, 20'h1_0000, 0, 1'b0, 32'd0},
			'{OP_LDPOS, 32'd0, 32'd0, 32'd0, 20'd0, 0, 1'b0, 32'd0}
		};
		foreach (dir_rows[i]) begin
			r = '{dir_rows[i].dt, dir_rows[i].vz, dir_rows[i].vy, dir_rows[i].vx, dir_rows[i].op};
			send_step(r, 0, 1'b0, 32'd0);
		end
		wait_idle();

		// random phases; removal is sticky and no phase resets the block, so removal
		// is drawn only in the last two phases (phases 10 and 11)
		for (int phase = 0; phase < 12; phase++) begin
			random_config(phase % 5);
			stall_always = (phase == 4);
			if (phase == 2) hold_off = 400;
			phase_left = N_RANDOM / 12;
			while (phase_left > 0) begin
				int pick;
				pick = $urandom_range(0, 99);
				r.op = (pick < 35) ? OP_INTEG : (pick < 60) ? OP_FORCE : (pick < 75) ? OP_LDPOS :
					(pick < 90) ? OP_LDVEL : (pick < 97) ? 3'($urandom_range(5, 7)) :
					(phase >= 10) ? OP_REMOVE : OP_FORCE;
				r.vx = rand_vec();
				r.vy = rand_vec();
				r.vz = rand_vec();
				r.dt = rand_dt();
				send_step(r, 0, 1'b0, 32'd0);
				phase_left--;
			end
			wait_idle();
		end
		stall_always = 0;

		wait_idle();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("tb_particle_euler_integrator_top passed");
		end else begin
			$display("tb_particle_euler_integrator_top failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* particle_euler_integrator_top.f */
rtl/pei_pkg.sv
rtl/pei_mul.sv
rtl/particle_euler_integrator_top.sv
sim/tb_particle_euler_integrator_top.sv
